/* design/khl_pkg.sv */
package khl_pkg;

	localparam int ROW_LEN = 64;
	localparam int KW_MAX  = 128;
	localparam int KW_LEN  = 16;

	localparam int RA    = $clog2(ROW_LEN);
	localparam int RC_W  = $clog2(ROW_LEN + 1);
	localparam int IW    = $clog2(ROW_LEN + KW_LEN + 1);
	localparam int KI_W  = $clog2(KW_MAX);
	localparam int KJ_W  = $clog2(KW_MAX + 1);
	localparam int KL_W  = $clog2(KW_LEN + 1);
	localparam int KT_AW = $clog2(KW_MAX * KW_LEN);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [1:0] ACT_KW     = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_HL     = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	localparam logic [2:0] CLS_NORMAL = 3'd0;
	localparam logic [2:0] CLS_LINE   = 3'd1;
	localparam logic [2:0] CLS_BLOCK  = 3'd2;
	localparam logic [2:0] CLS_KEY    = 3'd3;
	localparam logic [2:0] CLS_TYPE   = 3'd4;
	localparam logic [2:0] CLS_STR    = 3'd5;
	localparam logic [2:0] CLS_NUM    = 3'd6;

	localparam logic [2:0] REG_LINE_CHARS = 3'd0;
	localparam logic [2:0] REG_LINE_LEN   = 3'd1;
	localparam logic [2:0] REG_BS_CHARS   = 3'd2;
	localparam logic [2:0] REG_BS_LEN     = 3'd3;
	localparam logic [2:0] REG_BE_CHARS   = 3'd4;
	localparam logic [2:0] REG_BE_LEN     = 3'd5;
	localparam logic [2:0] REG_STR_EN     = 3'd6;
	localparam logic [2:0] REG_NUM_EN     = 3'd7;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [15:0] line_chars;
		logic [1:0]  line_len;
		logic [15:0] bs_chars;
		logic [1:0]  bs_len;
		logic [15:0] be_chars;
		logic [1:0]  be_len;
		logic        str_en;
		logic        num_en;
	} khl_cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_DEC,
		S_KM,
		S_KL,
		S_KC,
		S_KS,
		S_FILL,
		S_ORD,
		S_OLD,
		S_OWT
	} khl_state_t;

	function automatic logic [1:0] clamp2(input logic [1:0] l);
		return (l == 2'd3) ? 2'd2 : l;
	endfunction

	function automatic logic pat_match(input logic [15:0] chars, input logic [1:0] len,
			input logic [7:0] a, input logic [7:0] b);
		logic m0;
		logic m1;
		m0 = (a == chars[7:0]);
		m1 = (b == chars[15:8]);
		return (len == 2'd0) || (len == 2'd1 && m0) || (len == 2'd2 && m0 && m1);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) ||
			c == "," || c == "." || c == "(" || c == ")" || c == "+" || c == "-" ||
			c == "/" || c == "*" || c == "=" || c == "~" || c == "%" || c == "<" ||
			c == ">" || c == "[" || c == "]" || c == ";";
	endfunction

endpackage

/* design/khl_in_if.sv */
interface khl_in_if;
	import khl_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_byte;
	logic [6:0] kw_index;
	logic [3:0] kw_pos;
	logic [4:0] kw_length;
	logic       kw_secondary;
	logic       prev_open_comment;
	logic       old_open_comment;

	modport source (output valid, action, char_byte, kw_index, kw_pos, kw_length,
		kw_secondary, prev_open_comment, old_open_comment, input ready);
	modport sink (input valid, action, char_byte, kw_index, kw_pos, kw_length,
		kw_secondary, prev_open_comment, old_open_comment, output ready);
endinterface

/* design/khl_out_if.sv */
interface khl_out_if;
	import khl_pkg::*;
	logic       valid;
	logic       ready;
	logic [5:0] position;
	logic [2:0] hl_class;
	logic       char_valid;
	logic       open_comment;
	logic       open_changed;
	logic       last;

	modport source (output valid, position, hl_class, char_valid, open_comment,
		open_changed, last, input ready);
	modport sink (input valid, position, hl_class, char_valid, open_comment,
		open_changed, last, output ready);
endinterface

/* design/keyword_syntax_highlighter_core.sv */
// Keyword syntax highlighter. Load keyword bytes (action 0) and row characters
// (action 1) through the input channel at one word per cycle while idle; action 2
// then classifies the stored row and returns one result word per character (one
// word with char_valid low for an empty row), the last word carrying the outgoing
// open-comment flag. A highlight runs a sequencer over one-read, one-write row,
// keyword and class memories: per decoded position it reads (S_RD0, S_RD1),
// decodes (S_DEC) and writes the class of each covered character (S_FILL); after
// a separator it first tries keyword entries in list order (S_KM, S_KL, S_KC per
// keyword byte, S_KS). Each result word is read (S_ORD, S_OLD) and held for the
// sink (S_OWT). Keyword lengths reset to an empty list through per-entry valid
// flags, so no clearing pass follows reset. Comment delimiters, string and number
// options sit in the APB registers; the user is to change them only while the
// block is idle, and the block itself has no check for this.
module keyword_syntax_highlighter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [khl_pkg::PADDR_W-1:0] paddr,
	input  logic [khl_pkg::PDATA_W-1:0] pwdata,
	output logic [khl_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	khl_in_if.sink                      in_ch,
	khl_out_if.source                   out_ch
);
	import khl_pkg::*;

	khl_cfg_t cfg;

	khl_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	khl_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);
endmodule

/* design/khl_ram.sv */
module khl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/khl_cfg_regs.sv */
module khl_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [khl_pkg::PADDR_W-1:0] paddr,
	input  logic [khl_pkg::PDATA_W-1:0] pwdata,
	output logic [khl_pkg::PDATA_W-1:0] prdata,
	output logic                    pready,
	output khl_pkg::khl_cfg_t       cfg
);
	import khl_pkg::*;

	khl_cfg_t   cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_LINE_CHARS: cfg_q.line_chars <= pwdata[15:0];
				REG_LINE_LEN:   cfg_q.line_len   <= pwdata[1:0];
				REG_BS_CHARS:   cfg_q.bs_chars   <= pwdata[15:0];
				REG_BS_LEN:     cfg_q.bs_len     <= pwdata[1:0];
				REG_BE_CHARS:   cfg_q.be_chars   <= pwdata[15:0];
				REG_BE_LEN:     cfg_q.be_len     <= pwdata[1:0];
				REG_STR_EN:     cfg_q.str_en     <= pwdata[0];
				REG_NUM_EN:     cfg_q.num_en     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_LINE_CHARS: prdata[15:0] = cfg_q.line_chars;
			REG_LINE_LEN:   prdata[1:0]  = cfg_q.line_len;
			REG_BS_CHARS:   prdata[15:0] = cfg_q.bs_chars;
			REG_BS_LEN:     prdata[1:0]  = cfg_q.bs_len;
			REG_BE_CHARS:   prdata[15:0] = cfg_q.be_chars;
			REG_BE_LEN:     prdata[1:0]  = cfg_q.be_len;
			REG_STR_EN:     prdata[0]    = cfg_q.str_en;
			REG_NUM_EN:     prdata[0]    = cfg_q.num_en;
			default: ;
		endcase
	end
endmodule

/* design/khl_engine.sv */
module khl_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  khl_pkg::khl_cfg_t cfg,
	khl_in_if.sink            in_ch,
	khl_out_if.source         out_ch
);
	import khl_pkg::*;

	khl_state_t state_q, state_d;
	logic [RC_W-1:0] row_count_q, row_count_d;
	logic [IW-1:0]   i_q, i_d;
	logic [7:0]      c0_q, c0_d;
	logic            in_com_q, in_com_d;
	logic            str_on_q, str_on_d;
	logic [7:0]      quote_q, quote_d;
	logic            after_sep_q, after_sep_d;
	logic [2:0]      prev_hl_q, prev_hl_d;
	logic            old_q, old_d;
	logic [KJ_W-1:0] j_q, j_d;
	logic [KL_W-1:0] k_q, k_d;
	logic [KL_W-1:0] klen_q, klen_d;
	logic            ktype_q, ktype_d;
	logic [IW-1:0]   fill_pos_q, fill_pos_d;
	logic [IW-1:0]   fill_end_q, fill_end_d;
	logic [2:0]      fill_cls_q, fill_cls_d;
	logic [RA-1:0]   oidx_q, oidx_d;
	logic            o_valid_q, o_valid_d;
	logic [5:0]      o_pos_q, o_pos_d;
	logic [2:0]      o_cls_q, o_cls_d;
	logic            o_cv_q, o_cv_d;
	logic            o_oc_q, o_oc_d;
	logic            o_ch_q, o_ch_d;
	logic            o_last_q, o_last_d;

	logic            rowin_q;
	logic            kv_rd_q;
	logic [KW_MAX-1:0] kv_q;

	logic            in_acc;
	logic            kw_we_ok;
	logic            kt_we;
	logic [KI_W-1:0] kw_idx;
	logic [KL_W-1:0] kw_len_sat;
	logic            row_we;
	logic [IW-1:0]   row_raddr;
	logic [7:0]      row_rdata;
	logic [7:0]      ch;
	logic            cls_we;
	logic [2:0]      cls_rdata;
	logic [KT_AW-1:0] kt_waddr, kt_raddr;
	logic [7:0]      kt_rdata;
	logic [KI_W-1:0] km_raddr;
	logic [KL_W:0]   km_rdata;
	logic [IW-1:0]   n_w;
	logic [1:0]      slen, bslen, belen;
	logic            blk_on, digit;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign kw_idx      = KI_W'(in_ch.kw_index);
	assign kw_we_ok    = in_acc && (in_ch.action == ACT_KW) && (int'(in_ch.kw_index) < KW_MAX);
	assign kt_we       = kw_we_ok && (int'(in_ch.kw_pos) < KW_LEN);
	assign kw_len_sat  = (int'(in_ch.kw_length) > KW_LEN) ? KL_W'(KW_LEN)
		: KL_W'(in_ch.kw_length);
	assign kt_waddr    = KT_AW'(int'(kw_idx) * KW_LEN + int'(in_ch.kw_pos));
	assign row_we      = in_acc && (in_ch.action == ACT_APPEND) && (int'(row_count_q) < ROW_LEN);
	assign n_w         = IW'(row_count_q);
	assign ch          = rowin_q ? row_rdata : 8'h00;
	assign slen        = clamp2(cfg.line_len);
	assign bslen       = clamp2(cfg.bs_len);
	assign belen       = clamp2(cfg.be_len);
	assign blk_on      = (bslen != 2'd0) && (belen != 2'd0);
	assign digit       = (c0_q >= CH_ZERO) && (c0_q <= CH_NINE);

	khl_ram #(.WIDTH(8), .DEPTH(ROW_LEN)) u_row (
		.clk(clk), .we(row_we), .waddr(row_count_q[RA-1:0]), .wdata(in_ch.char_byte),
		.raddr(row_raddr[RA-1:0]), .rdata(row_rdata)
	);

	khl_ram #(.WIDTH(3), .DEPTH(ROW_LEN)) u_cls (
		.clk(clk), .we(cls_we), .waddr(fill_pos_q[RA-1:0]), .wdata(fill_cls_q),
		.raddr(oidx_q), .rdata(cls_rdata)
	);

	khl_ram #(.WIDTH(8), .DEPTH(KW_MAX * KW_LEN)) u_kt (
		.clk(clk), .we(kt_we), .waddr(kt_waddr), .wdata(in_ch.char_byte),
		.raddr(kt_raddr), .rdata(kt_rdata)
	);

	khl_ram #(.WIDTH(KL_W + 1), .DEPTH(KW_MAX)) u_km (
		.clk(clk), .we(kw_we_ok), .waddr(kw_idx), .wdata({in_ch.kw_secondary, kw_len_sat}),
		.raddr(km_raddr), .rdata(km_rdata)
	);

	always_comb begin
		logic do_next;
		logic do_miss;
		logic last_w;
		do_next    = 1'b0;
		do_miss    = 1'b0;
		last_w     = (RC_W'(oidx_q) + RC_W'(1)) == row_count_q;
		state_d    = state_q;
		row_count_d = row_count_q;
		i_d        = i_q;
		c0_d       = c0_q;
		in_com_d   = in_com_q;
		str_on_d   = str_on_q;
		quote_d    = quote_q;
		after_sep_d = after_sep_q;
		prev_hl_d  = prev_hl_q;
		old_d      = old_q;
		j_d        = j_q;
		k_d        = k_q;
		klen_d     = klen_q;
		ktype_d    = ktype_q;
		fill_pos_d = fill_pos_q;
		fill_end_d = fill_end_q;
		fill_cls_d = fill_cls_q;
		oidx_d     = oidx_q;
		o_valid_d  = o_valid_q;
		o_pos_d    = o_pos_q;
		o_cls_d    = o_cls_q;
		o_cv_d     = o_cv_q;
		o_oc_d     = o_oc_q;
		o_ch_d     = o_ch_q;
		o_last_d   = o_last_q;
		row_raddr  = i_q;
		kt_raddr   = KT_AW'(int'(j_q) * KW_LEN);
		km_raddr   = j_q[KI_W-1:0];
		cls_we     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (row_we) begin
					row_count_d = row_count_q + RC_W'(1);
				end
				if (in_acc && in_ch.action == ACT_HL) begin
					in_com_d   = in_ch.prev_open_comment;
					old_d      = in_ch.old_open_comment;
					str_on_d   = 1'b0;
					quote_d    = 8'h00;
					after_sep_d = 1'b1;
					prev_hl_d  = CLS_NORMAL;
					i_d        = '0;
					oidx_d     = '0;
					if (row_count_q == '0) begin
						o_valid_d = 1'b1;
						o_pos_d   = '0;
						o_cls_d   = CLS_NORMAL;
						o_cv_d    = 1'b0;
						o_last_d  = 1'b1;
						o_oc_d    = in_ch.prev_open_comment;
						o_ch_d    = in_ch.prev_open_comment != in_ch.old_open_comment;
						state_d   = S_OWT;
					end else begin
						state_d = S_RD0;
					end
				end
			end
			S_RD0: begin
				row_raddr = i_q;
				state_d   = S_RD1;
			end
			S_RD1: begin
				row_raddr = i_q + IW'(1);
				c0_d      = ch;
				state_d   = S_DEC;
			end
			S_DEC: begin
				state_d    = S_FILL;
				fill_pos_d = i_q;
				fill_end_d = i_q + IW'(1);
				priority if (slen != 2'd0 && !str_on_q && !in_com_q &&
						pat_match(cfg.line_chars, slen, c0_q, ch)) begin
					fill_end_d = n_w;
					fill_cls_d = CLS_LINE;
				end else if (blk_on && !str_on_q && in_com_q) begin
					fill_cls_d = CLS_BLOCK;
					if (pat_match(cfg.be_chars, belen, c0_q, ch)) begin
						fill_end_d = i_q + IW'(belen);
						in_com_d   = 1'b0;
						after_sep_d = 1'b1;
					end
				end else if (blk_on && !str_on_q && pat_match(cfg.bs_chars, bslen, c0_q, ch)) begin
					fill_end_d = i_q + IW'(bslen);
					fill_cls_d = CLS_BLOCK;
					in_com_d   = 1'b1;
				end else if (cfg.str_en && str_on_q) begin
					fill_cls_d = CLS_STR;
					if (c0_q == CH_BSLASH && (i_q + IW'(1)) < n_w) begin
						fill_end_d = i_q + IW'(2);
					end else begin
						if (c0_q == quote_q) begin
							str_on_d = 1'b0;
						end
						after_sep_d = 1'b1;
					end
				end else if (cfg.str_en && (c0_q == CH_DQUOTE || c0_q == CH_SQUOTE)) begin
					fill_cls_d = CLS_STR;
					str_on_d   = 1'b1;
					quote_d    = c0_q;
				end else if (cfg.num_en && ((digit && (after_sep_q || prev_hl_q == CLS_NUM)) ||
						(c0_q == CH_DOT && prev_hl_q == CLS_NUM))) begin
					fill_cls_d = CLS_NUM;
					after_sep_d = 1'b0;
				end else if (after_sep_q) begin
					j_d     = '0;
					state_d = S_KM;
				end else begin
					after_sep_d = is_sep(c0_q);
					fill_cls_d = CLS_NORMAL;
				end
			end
			S_KM: begin
				km_raddr = j_q[KI_W-1:0];
				state_d  = S_KL;
			end
			S_KL: begin
				if (!kv_rd_q || km_rdata[KL_W-1:0] == '0) begin
					do_miss = 1'b1;
				end else begin
					klen_d    = km_rdata[KL_W-1:0];
					ktype_d   = km_rdata[KL_W];
					k_d       = '0;
					row_raddr = i_q;
					kt_raddr  = KT_AW'(int'(j_q) * KW_LEN);
					state_d   = S_KC;
				end
			end
			S_KC: begin
				if (ch != kt_rdata) begin
					do_next = 1'b1;
				end else if ((k_q + KL_W'(1)) == klen_q) begin
					row_raddr = i_q + IW'(klen_q);
					state_d   = S_KS;
				end else begin
					k_d       = k_q + KL_W'(1);
					row_raddr = i_q + IW'(k_q) + IW'(1);
					kt_raddr  = KT_AW'(int'(j_q) * KW_LEN + int'(k_q) + 1);
					state_d   = S_KC;
				end
			end
			S_KS: begin
				if (is_sep(ch)) begin
					fill_pos_d = i_q;
					fill_end_d = i_q + IW'(klen_q);
					fill_cls_d = ktype_q ? CLS_TYPE : CLS_KEY;
					after_sep_d = 1'b0;
					state_d    = S_FILL;
				end else begin
					do_next = 1'b1;
				end
			end
			S_FILL: begin
				if (fill_pos_q < fill_end_q && fill_pos_q < n_w) begin
					cls_we     = 1'b1;
					fill_pos_d = fill_pos_q + IW'(1);
				end else begin
					i_d       = fill_end_q;
					prev_hl_d = fill_cls_q;
					if (fill_end_q >= n_w) begin
						oidx_d  = '0;
						state_d = S_ORD;
					end else begin
						state_d = S_RD0;
					end
				end
			end
			S_ORD: begin
				state_d = S_OLD;
			end
			S_OLD: begin
				o_valid_d = 1'b1;
				o_pos_d   = 6'(oidx_q);
				o_cls_d   = cls_rdata;
				o_cv_d    = 1'b1;
				o_last_d  = last_w;
				o_oc_d    = last_w && in_com_q;
				o_ch_d    = last_w && (in_com_q != old_q);
				state_d   = S_OWT;
			end
			S_OWT: begin
				if (out_ch.ready) begin
					o_valid_d = 1'b0;
					if (o_last_q) begin
						row_count_d = '0;
						state_d     = S_IDLE;
					end else begin
						oidx_d  = oidx_q + RA'(1);
						state_d = S_ORD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (do_next) begin
			j_d = j_q + KJ_W'(1);
			if ((int'(j_q) + 1) >= KW_MAX) begin
				do_miss = 1'b1;
			end else begin
				state_d = S_KM;
			end
		end
		if (do_miss) begin
			after_sep_d = is_sep(c0_q);
			fill_pos_d = i_q;
			fill_end_d = i_q + IW'(1);
			fill_cls_d = CLS_NORMAL;
			state_d    = S_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_count_q <= '0;
			o_valid_q   <= 1'b0;
			kv_q        <= '0;
		end else begin
			state_q     <= state_d;
			row_count_q <= row_count_d;
			o_valid_q   <= o_valid_d;
			if (kw_we_ok) begin
				kv_q[kw_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q        <= i_d;
		c0_q       <= c0_d;
		in_com_q   <= in_com_d;
		str_on_q   <= str_on_d;
		quote_q    <= quote_d;
		after_sep_q <= after_sep_d;
		prev_hl_q  <= prev_hl_d;
		old_q      <= old_d;
		j_q        <= j_d;
		k_q        <= k_d;
		klen_q     <= klen_d;
		ktype_q    <= ktype_d;
		fill_pos_q <= fill_pos_d;
		fill_end_q <= fill_end_d;
		fill_cls_q <= fill_cls_d;
		oidx_q     <= oidx_d;
		o_pos_q    <= o_pos_d;
		o_cls_q    <= o_cls_d;
		o_cv_q     <= o_cv_d;
		o_oc_q     <= o_oc_d;
		o_ch_q     <= o_ch_d;
		o_last_q   <= o_last_d;
		rowin_q    <= row_raddr < n_w;
		kv_rd_q    <= kv_q[km_raddr];
	end

	assign out_ch.valid        = o_valid_q;
	assign out_ch.position     = o_pos_q;
	assign out_ch.hl_class     = o_cls_q;
	assign out_ch.char_valid   = o_cv_q;
	assign out_ch.open_comment = o_oc_q;
	assign out_ch.open_changed = o_ch_q;
	assign out_ch.last         = o_last_q;

`ifndef ASSERT_OFF
	a_valid_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> state_q == S_OWT)
		else $error("result word valid outside the output wait state");
	a_row_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> $stable(row_count_q))
		else $error("row length moved during a highlight");
	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last) |=> row_count_q == '0)
		else $error("row length not cleared after the final word");
	a_kw_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KC) |-> (k_q < klen_q))
		else $error("keyword compare ran past the keyword length");
`endif
endmodule

/* test/keyword_syntax_highlighter_core_test.sv */
module keyword_syntax_highlighter_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import khl_pkg::*;

	typedef struct {
		logic [5:0] position;
		logic [2:0] hl_class;
		logic       char_valid;
		logic       open_comment;
		logic       open_changed;
		logic       last;
	} hl_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	khl_in_if  in_ch ();
	khl_out_if out_ch ();

	keyword_syntax_highlighter_core uut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// shadow of the block state
	logic [7:0]  row_mem [ROW_LEN];
	int          row_n;
	logic [2:0]  class_mem [ROW_LEN];
	logic [7:0]  kw_text_mem [KW_MAX][KW_LEN];
	int          kw_len_mem [KW_MAX];
	bit          kw_type_mem [KW_MAX];
	logic [15:0] line_chars, bs_chars, be_chars;
	logic [1:0]  line_len, bs_len, be_len;
	logic        str_en, num_en;

	hl_word_t    pending_words[$];
	int          src_idle, snk_idle;
	int          errors, items_sent, rows_done, words_seen;

	// generator keyword list
	logic [7:0]  word_bytes [10][KW_LEN];
	int          word_len [10];
	bit          word_type [10];
	int          word_count;

	string       sep_chars = ",.()+-/*=~%<>[];";

	function automatic logic [7:0] row_char(int i);
		return (i < row_n && i < ROW_LEN) ? row_mem[i] : 8'h00;
	endfunction

	function automatic bit separator(logic [7:0] c);
		if (c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			return 1'b1;
		for (int k = 0; k < sep_chars.len(); k++)
			if (sep_chars[k] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int sat2(logic [1:0] l);
		return (l == 2'd3) ? 2 : int'(l);
	endfunction

	function automatic bit delim_at(int i, logic [15:0] chars, int len);
		for (int k = 0; k < len; k++)
			if (row_char(i + k) != chars[8*k +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void mark(int i, int n, logic [2:0] c);
		for (int k = 0; k < n; k++)
			if (i + k < row_n && i + k < ROW_LEN)
				class_mem[i + k] = c;
	endfunction

	function automatic bit word_at(int i, int j, int len);
		for (int k = 0; k < len; k++)
			if (row_char(i + k) != kw_text_mem[j][k])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void classify_row(bit in_com, bit old_com);
		int         n, slen, bslen, belen, i, j, klen;
		bit         after_sep, str_on, hit, digit;
		logic [7:0] quote, c;
		logic [2:0] prev_hl;
		hl_word_t   w;
		n = row_n;
		slen = sat2(line_len);
		bslen = sat2(bs_len);
		belen = sat2(be_len);
		after_sep = 1'b1;
		str_on = 1'b0;
		quote = 8'h00;
		i = 0;
		for (int k = 0; k < ROW_LEN; k++)
			class_mem[k] = CLS_NORMAL;
		while (i < n) begin
			c = row_mem[i];
			prev_hl = (i > 0) ? class_mem[i - 1] : CLS_NORMAL;
			if (slen != 0 && !str_on && !in_com && delim_at(i, line_chars, slen)) begin
				mark(i, n - i, CLS_LINE);
				break;
			end
			if (bslen != 0 && belen != 0 && !str_on) begin
				if (in_com) begin
					class_mem[i] = CLS_BLOCK;
					if (delim_at(i, be_chars, belen)) begin
						mark(i, belen, CLS_BLOCK);
						i += belen;
						in_com = 1'b0;
						after_sep = 1'b1;
						continue;
					end
					i++;
					continue;
				end else if (delim_at(i, bs_chars, bslen)) begin
					mark(i, bslen, CLS_BLOCK);
					i += bslen;
					in_com = 1'b1;
					continue;
				end
			end
			if (str_en) begin
				if (str_on) begin
					class_mem[i] = CLS_STR;
					if (c == CH_BSLASH && i + 1 < n) begin
						class_mem[i + 1] = CLS_STR;
						i += 2;
						continue;
					end
					if (c == quote)
						str_on = 1'b0;
					i++;
					after_sep = 1'b1;
					continue;
				end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					str_on = 1'b1;
					quote = c;
					class_mem[i] = CLS_STR;
					i++;
					continue;
				end
			end
			if (num_en) begin
				digit = (c >= CH_ZERO && c <= CH_NINE);
				if ((digit && (after_sep || prev_hl == CLS_NUM)) ||
						(c == CH_DOT && prev_hl == CLS_NUM)) begin
					class_mem[i] = CLS_NUM;
					i++;
					after_sep = 1'b0;
					continue;
				end
			end
			if (after_sep) begin
				hit = 1'b0;
				for (j = 0; j < KW_MAX && kw_len_mem[j] != 0; j++) begin
					klen = kw_len_mem[j];
					if (word_at(i, j, klen) && separator(row_char(i + klen))) begin
						mark(i, klen, kw_type_mem[j] ? CLS_TYPE : CLS_KEY);
						i += klen;
						hit = 1'b1;
						break;
					end
				end
				if (hit) begin
					after_sep = 1'b0;
					continue;
				end
			end
			after_sep = separator(c);
			i++;
		end
		if (n == 0) begin
			w = '{6'd0, CLS_NORMAL, 1'b0, in_com, in_com != old_com, 1'b1};
			pending_words.push_back(w);
		end
		for (int k = 0; k < n; k++) begin
			w.position = k[5:0];
			w.hl_class = class_mem[k];
			w.char_valid = 1'b1;
			w.last = (k == n - 1);
			w.open_comment = w.last & in_com;
			w.open_changed = w.last & (in_com != old_com);
			pending_words.push_back(w);
		end
		row_n = 0;
		rows_done++;
	endfunction

	task automatic send(logic [1:0] act, logic [7:0] ch, logic [6:0] idx, logic [3:0] pos,
			logic [4:0] len, logic sec, logic prev_com, logic old_com);
		int l;
		while ($urandom_range(0, 99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.char_byte <= ch;
		in_ch.kw_index <= idx;
		in_ch.kw_pos <= pos;
		in_ch.kw_length <= len;
		in_ch.kw_secondary <= sec;
		in_ch.prev_open_comment <= prev_com;
		in_ch.old_open_comment <= old_com;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		case (act)
			ACT_KW: begin
				l = (len > KW_LEN) ? KW_LEN : int'(len);
				kw_text_mem[idx][pos] = ch;
				kw_len_mem[idx] = l;
				kw_type_mem[idx] = sec;
			end
			ACT_APPEND: begin
				if (row_n < ROW_LEN) begin
					row_mem[row_n] = ch;
					row_n++;
				end
			end
			ACT_HL: classify_row(prev_com, old_com);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic put_char(logic [7:0] ch);
		send(ACT_APPEND, ch, 7'($urandom), 4'($urandom), 5'($urandom), 1'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	task automatic put_text(string s);
		for (int k = 0; k < s.len(); k++)
			put_char(s[k]);
	endtask

	task automatic highlight(bit prev_com, bit old_com);
		send(ACT_HL, 8'($urandom), 7'($urandom), 4'($urandom), 5'($urandom), 1'($urandom),
			prev_com, old_com);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] r, logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (r)
			REG_LINE_CHARS: line_chars = v[15:0];
			REG_LINE_LEN:   line_len = v[1:0];
			REG_BS_CHARS:   bs_chars = v[15:0];
			REG_BS_LEN:     bs_len = v[1:0];
			REG_BE_CHARS:   be_chars = v[15:0];
			REG_BE_LEN:     be_len = v[1:0];
			REG_STR_EN:     str_en = v[0];
			REG_NUM_EN:     num_en = v[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] lc, logic [1:0] ll, logic [15:0] bsc,
			logic [1:0] bsl, logic [15:0] bec, logic [1:0] bel, logic s, logic nm);
		reg_write(REG_LINE_CHARS, 32'(lc));
		reg_write(REG_LINE_LEN, 32'(ll));
		reg_write(REG_BS_CHARS, 32'(bsc));
		reg_write(REG_BS_LEN, 32'(bsl));
		reg_write(REG_BE_CHARS, 32'(bec));
		reg_write(REG_BE_LEN, 32'(bel));
		reg_write(REG_STR_EN, 32'(s));
		reg_write(REG_NUM_EN, 32'(nm));
	endtask

	function automatic void set_word(int w, string s, bit t);
		word_len[w] = s.len();
		word_type[w] = t;
		for (int k = 0; k < s.len(); k++)
			word_bytes[w][k] = s[k];
	endfunction

	// load the whole generator list, every byte of every entry, then end it
	task automatic load_words(logic [4:0] len_override);
		logic [4:0] l;
		for (int w = 0; w < word_count; w++) begin
			l = (len_override != 0) ? len_override : 5'(word_len[w]);
			for (int k = 0; k < word_len[w]; k++)
				send(ACT_KW, word_bytes[w][k], 7'(w), 4'(k), l, word_type[w],
					1'($urandom), 1'($urandom));
		end
		send(ACT_KW, 8'($urandom), 7'(word_count), 4'($urandom), 5'd0, 1'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	function automatic logic [7:0] pick_delim_byte();
		string pool = "/*#-;!";
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'($urandom);
			default: return pool[$urandom_range(0, pool.len() - 1)];
		endcase
	endfunction

	task automatic random_config();
		configure({pick_delim_byte(), pick_delim_byte()}, 2'($urandom),
			{pick_delim_byte(), pick_delim_byte()}, 2'($urandom),
			{pick_delim_byte(), pick_delim_byte()}, 2'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	task automatic random_words();
		string letters = "abcxyz";
		word_count = $urandom_range(1, 8);
		for (int w = 0; w < word_count; w++) begin
			word_len[w] = $urandom_range(1, 5);
			word_type[w] = 1'($urandom);
			for (int k = 0; k < word_len[w]; k++)
				word_bytes[w][k] = letters[$urandom_range(0, letters.len() - 1)];
		end
		load_words(5'd0);
	endtask

	task automatic random_row();
		int target, cnt, w;
		string pool = "\"'\\ 0123456789.abxyz_";
		target = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 24);
		cnt = 0;
		while (cnt < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					w = $urandom_range(0, word_count - 1);
					for (int k = 0; k < word_len[w]; k++)
						put_char(word_bytes[w][k]);
					cnt += word_len[w];
				end
				3: begin
					put_char(sep_chars[$urandom_range(0, sep_chars.len() - 1)]);
					cnt++;
				end
				4, 5, 6: begin
					put_char(pool[$urandom_range(0, pool.len() - 1)]);
					cnt++;
				end
				7: begin
					case ($urandom_range(0, 5))
						0: put_char(line_chars[7:0]);
						1: put_char(line_chars[15:8]);
						2: put_char(bs_chars[7:0]);
						3: put_char(bs_chars[15:8]);
						4: put_char(be_chars[7:0]);
						default: put_char(be_chars[15:8]);
					endcase
					cnt++;
				end
				8: begin
					send(ACT_NOP, 8'($urandom), 7'($urandom), 4'($urandom), 5'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom));
				end
				default: begin
					put_char(8'($urandom));
					cnt++;
				end
			endcase
		end
		highlight(1'($urandom), 1'($urandom));
	endtask

	task automatic test_keywords();
		word_count = 6;
		set_word(0, "if", 1'b0);
		set_word(1, "int", 1'b1);
		set_word(2, "while", 1'b0);
		set_word(3, "abcdefghijklmnop", 1'b1);
		set_word(4, "q?", 1'b0);
		word_bytes[4][1] = 8'h00;
		set_word(5, "x", 1'b1);
		configure(16'h2F2F, 2'd2, 16'h2A2F, 2'd2, 16'h2F2A, 2'd2, 1'b1, 1'b1);
		load_words(5'd31);
		word_len[3] = 16;
		// a dead entry past the list end
		for (int k = 0; k < KW_LEN; k++)
			send(ACT_KW, 8'hFF, 7'd127, 4'(k), 5'd16, 1'b1, 1'b1, 1'b1);
		drain();
		load_words(5'd0);
		put_text("if(x) int y;abcdefghijklmnop");
		highlight(1'b0, 1'b0);
		put_text("while 12.5 x3 3x ifx 7.");
		highlight(1'b0, 1'b1);
		put_text("\"a\\\"b\" 'c' if \"ab\\");
		highlight(1'b0, 1'b0);
		put_text("a // if int");
		highlight(1'b0, 1'b0);
		put_text("x */ int /* if");
		highlight(1'b1, 1'b0);
		highlight(1'b1, 1'b0);
		put_text("q");
		highlight(1'b0, 1'b0);
		put_text(" q");
		put_char(8'h00);
		highlight(1'b0, 1'b0);
		for (int k = 0; k < ROW_LEN + 6; k++)
			put_char((k % 5 == 4) ? 8'h20 : 8'h69 + 8'(k % 2) * 8'h05);
		highlight(1'b0, 1'b1);
		send(ACT_NOP, 8'hFF, 7'h7F, 4'hF, 5'h1F, 1'b1, 1'b1, 1'b1);
		highlight(1'b1, 1'b1);
		drain();
	endtask

	task automatic test_comment_corners();
		// block comments off: an open comment stays open and line comments are ignored only inside it
		configure(16'h2F2F, 2'd2, 16'h2A2F, 2'd0, 16'h2F2A, 2'd2, 1'b0, 1'b0);
		put_text("// int 12");
		highlight(1'b1, 1'b0);
		put_text("// int 12");
		highlight(1'b0, 1'b0);
		drain();
		// length three saturates, zero bytes and all-ones as delimiters
		configure(16'hFFFF, 2'd3, 16'h0000, 2'd3, 16'hFF00, 2'd3, 1'b1, 1'b0);
		put_text("int ");
		put_char(8'h00);
		put_char(8'h00);
		put_text("if ");
		put_char(8'hFF);
		put_char(8'hFF);
		put_text(" x");
		highlight(1'b0, 1'b1);
		put_text("ab");
		put_char(8'h00);
		put_char(8'hFF);
		put_text(" int");
		highlight(1'b1, 1'b1);
		drain();
		configure(16'h0023, 2'd1, 16'h007B, 2'd1, 16'h007D, 2'd1, 1'b1, 1'b1);
		put_text("a{b}c 1 'x#' # int");
		highlight(1'b0, 1'b0);
		drain();
	endtask

	task automatic test_random(int src_pct, int snk_pct, int count);
		int stop;
		src_idle = src_pct;
		snk_idle = snk_pct;
		stop = items_sent + count;
		drain();
		random_config();
		random_words();
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				drain();
				random_config();
			end
			if ($urandom_range(0, 11) == 0)
				random_words();
			random_row();
		end
		drain();
	endtask

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);

	always @(posedge clk) begin
		hl_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected word at position %0d", out_ch.position);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (out_ch.position !== e.position) begin
					$error("position: expected %0d, got %0d", e.position, out_ch.position);
					errors++;
				end
				if (out_ch.hl_class !== e.hl_class) begin
					$error("hl_class: expected %0d, got %0d", e.hl_class, out_ch.hl_class);
					errors++;
				end
				if (out_ch.char_valid !== e.char_valid) begin
					$error("char_valid: expected %0b, got %0b", e.char_valid, out_ch.char_valid);
					errors++;
				end
				if (out_ch.open_comment !== e.open_comment) begin
					$error("open_comment: expected %0b, got %0b", e.open_comment,
						out_ch.open_comment);
					errors++;
				end
				if (out_ch.open_changed !== e.open_changed) begin
					$error("open_changed: expected %0b, got %0b", e.open_changed,
						out_ch.open_changed);
					errors++;
				end
				if (out_ch.last !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, out_ch.last);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int waited;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_KW;
		in_ch.char_byte = '0;
		in_ch.kw_index = '0;
		in_ch.kw_pos = '0;
		in_ch.kw_length = '0;
		in_ch.kw_secondary = 1'b0;
		in_ch.prev_open_comment = 1'b0;
		in_ch.old_open_comment = 1'b0;
		out_ch.ready = 1'b0;
		row_n = 0;
		for (int k = 0; k < KW_MAX; k++) begin
			kw_len_mem[k] = 0;
			kw_type_mem[k] = 1'b0;
			for (int p = 0; p < KW_LEN; p++)
				kw_text_mem[k][p] = 8'h00;
		end
		{line_chars, bs_chars, be_chars} = '0;
		{line_len, bs_len, be_len, str_en, num_en} = '0;
		errors = 0;
		items_sent = 0;
		rows_done = 0;
		words_seen = 0;
		src_idle = 0;
		snk_idle = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		highlight(1'b0, 1'b1);
		drain();
		test_keywords();
		test_comment_corners();
		test_random(35, 53, 25);
		test_random(53, 35, 25);
		test_random(0, 0, 25);
		in_ch.valid <= 1'b0;
		waited = 0;
		while (pending_words.size() != 0 && waited < 500000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		$display("covered %0d input words, %0d rows highlighted, %0d result words checked",
			items_sent, rows_done, words_seen);
		$display("keyword lists, comment delimiters, strings and numbers over varied settings");
		if (errors == 0 && pending_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
